// ===== rtl/core/packet_sequence_tracker_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the packet sequence tracker
// Concurrent checks clocked on the rising edge, idle while reset is applied.
// ----------------------------------------------------------------------------
`ifndef PACKET_SEQUENCE_TRACKER_ASSERT_SVH
`define PACKET_SEQUENCE_TRACKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("packet_sequence_tracker: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("packet_sequence_tracker: next-cycle check failed");

`endif

// ===== rtl/core/pst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types and constants of the packet sequence tracker.
// ----------------------------------------------------------------------------
package pst_pkg;

    typedef enum logic [1:0] {
        VERDICT_NEW   = 2'd0,
        VERDICT_DUP   = 2'd1,
        VERDICT_SHORT = 2'd2,
        VERDICT_RANGE = 2'd3
    } verdict_t;

    localparam int unsigned LEN_W      = 16;
    localparam int unsigned STAMP_W    = 64;
    localparam int unsigned CFG_W      = 17;
    localparam int unsigned DELIV_W    = 17;
    localparam int unsigned DUP_W      = 32;
    localparam int unsigned REORD_W    = 16;
    localparam int unsigned MIN_LENGTH = 16;

    // seen bitmap is stored as rows of ROW_W bits
    localparam int unsigned ROW_BITS   = 4;
    localparam int unsigned ROW_W      = 1 << ROW_BITS;

    localparam logic [CFG_W-1:0] EXPECTED_RESET = 17'h10000;

endpackage

// ===== rtl/core/pst_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pst_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/packet_sequence_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_sequence_tracker
// Classifies received probe packets as new, duplicate, too short or out of
// range, and keeps saturating delivery, duplicate and reorder counts.
// ----------------------------------------------------------------------------
// Takes one packet request per clock while in_stall is low. A packet passes
// two register stages, the lookup stage and the output register. Throughput
// is set by the single read-modify-write of the seen bitmap RAM per packet,
// with the row written alongside a read forwarded to that read. A stalled
// result holds at most one more packet behind it before in_stall rises. The
// bitmap is held as SEQ_DEPTH/16 rows of 16 bits (rounded up). After reset a
// clearing pass zeroes one row per cycle, and in_stall stays high until every
// row is cleared; expected_total may be written during that time.
module packet_sequence_tracker
    import pst_pkg::*;
#(
    parameter int unsigned SEQ_DEPTH = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_W-1:0]   expected_total,
    // packet requests
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [LEN_W-1:0]   packet_length,
    input  logic [STAMP_W-1:0] seq_number,
    input  logic [STAMP_W-1:0] send_stamp,
    input  logic [STAMP_W-1:0] arrive_stamp,
    // results
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         verdict,
    output logic [STAMP_W-1:0] latency_ns,
    output logic               reordered,
    output logic [DELIV_W-1:0] delivered_total,
    output logic [DUP_W-1:0]   duplicate_total,
    output logic [REORD_W-1:0] reorder_total
);

    localparam int unsigned SEQ_W  = $clog2(SEQ_DEPTH);
    localparam int unsigned ROWS   = (SEQ_DEPTH + ROW_W - 1) / ROW_W;
    localparam int unsigned ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

    // configuration
    logic [CFG_W-1:0]   expected_reg;

    // clearing pass
    logic               clr_busy_reg;
    logic [ROW_AW-1:0]  clr_addr_reg;

    // lookup stage
    logic               s1_valid_reg;
    logic               s1_valid_next;
    verdict_t           s1_class_reg;
    logic [SEQ_W-1:0]   s1_idx_reg;
    logic [STAMP_W-1:0] s1_lat_reg;

    // forwarding of the row written in the cycle the current read was issued
    logic               fwd_vld_reg;
    logic [ROW_AW-1:0]  fwd_row_reg;
    logic [ROW_W-1:0]   fwd_data_reg;

    // counters
    logic [DELIV_W-1:0] deliv_cnt_reg;
    logic [DELIV_W-1:0] deliv_cnt_next;
    logic [DUP_W-1:0]   dup_cnt_reg;
    logic [DUP_W-1:0]   dup_cnt_next;
    logic [REORD_W-1:0] reord_cnt_reg;
    logic [REORD_W-1:0] reord_cnt_next;
    logic [SEQ_W-1:0]   last_seq_reg;
    logic               last_known_reg;

    // output register
    logic               out_valid_reg;
    logic               out_valid_next;
    verdict_t           verdict_reg;
    verdict_t           verdict_next;
    logic [STAMP_W-1:0] latency_reg;
    logic               reordered_reg;
    logic               reordered_next;
    logic [DELIV_W-1:0] deliv_out_reg;
    logic [DUP_W-1:0]   dup_out_reg;
    logic [REORD_W-1:0] reord_out_reg;

    // datapath
    logic               in_accept;
    logic               s1_adv;
    verdict_t           in_class;
    logic [SEQ_W-1:0]   in_idx;
    logic [ROW_AW-1:0]  in_row;
    logic [ROW_AW-1:0]  s1_row;
    logic [ROW_BITS-1:0] s1_bit;
    logic [ROW_W-1:0]   ram_rdata;
    logic [ROW_W-1:0]   row_cur;
    logic [ROW_W-1:0]   row_set;
    logic               seen;
    logic               item_we;
    logic               ram_we;
    logic [ROW_AW-1:0]  ram_waddr;
    logic [ROW_W-1:0]   ram_wdata;

    assign cfg_ready = 1'b1;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = clr_busy_reg || (s1_valid_reg && !s1_adv);
    assign in_accept = in_valid && !in_stall;

    assign in_idx = seq_number[SEQ_W-1:0];
    assign in_row = ROW_AW'({{ROW_AW{1'b0}}, in_idx} >> ROW_BITS);
    assign s1_row = ROW_AW'({{ROW_AW{1'b0}}, s1_idx_reg} >> ROW_BITS);
    assign s1_bit = s1_idx_reg[ROW_BITS-1:0];

    // length test first, then range against min(expected_total, depth)
    always_comb
    begin
        priority if (packet_length < LEN_W'(MIN_LENGTH))
        begin
            in_class = VERDICT_SHORT;
        end
        else if (seq_number >= STAMP_W'(expected_reg) ||
                 seq_number >= STAMP_W'(SEQ_DEPTH))
        begin
            in_class = VERDICT_RANGE;
        end
        else
        begin
            in_class = VERDICT_NEW;
        end
    end

    pst_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_seen_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (in_row),
        .rdata (ram_rdata)
    );

    assign row_cur = (fwd_vld_reg && fwd_row_reg == s1_row) ? fwd_data_reg : ram_rdata;
    assign row_set = row_cur | (ROW_W'(1) << s1_bit);
    assign seen    = row_cur[s1_bit];
    assign item_we = s1_adv && (s1_class_reg == VERDICT_NEW) && !seen;

    assign ram_we    = clr_busy_reg || item_we;
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : s1_row;
    assign ram_wdata = clr_busy_reg ? '0 : row_set;

    always_comb
    begin
        deliv_cnt_next = deliv_cnt_reg;
        dup_cnt_next   = dup_cnt_reg;
        reord_cnt_next = reord_cnt_reg;
        reordered_next = 1'b0;
        verdict_next   = s1_class_reg;
        if (s1_class_reg == VERDICT_NEW)
        begin
            if (seen)
            begin
                verdict_next = VERDICT_DUP;
                if (dup_cnt_reg != '1)
                begin
                    dup_cnt_next = dup_cnt_reg + 1'b1;
                end
            end
            else
            begin
                if (deliv_cnt_reg != '1)
                begin
                    deliv_cnt_next = deliv_cnt_reg + 1'b1;
                end
                if (last_known_reg && s1_idx_reg < last_seq_reg)
                begin
                    reordered_next = 1'b1;
                    if (reord_cnt_reg != '1)
                    begin
                        reord_cnt_next = reord_cnt_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg   <= EXPECTED_RESET;
            clr_busy_reg   <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            fwd_vld_reg    <= 1'b0;
            deliv_cnt_reg  <= '0;
            dup_cnt_reg    <= '0;
            reord_cnt_reg  <= '0;
            last_seq_reg   <= '0;
            last_known_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            deliv_out_reg  <= '0;
            dup_out_reg    <= '0;
            reord_out_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                expected_reg <= expected_total;
            end

            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ROW)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end

            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;

            // track the write that overlaps the read issued this cycle
            if (in_accept)
            begin
                fwd_vld_reg <= item_we;
            end

            if (s1_adv)
            begin
                deliv_cnt_reg <= deliv_cnt_next;
                dup_cnt_reg   <= dup_cnt_next;
                reord_cnt_reg <= reord_cnt_next;
                deliv_out_reg <= deliv_cnt_next;
                dup_out_reg   <= dup_cnt_next;
                reord_out_reg <= reord_cnt_next;
            end

            if (item_we)
            begin
                last_seq_reg   <= s1_idx_reg;
                last_known_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_class_reg <= in_class;
            s1_idx_reg   <= in_idx;
            s1_lat_reg   <= arrive_stamp - send_stamp;
            fwd_row_reg  <= s1_row;
            fwd_data_reg <= row_set;
        end
        if (s1_adv)
        begin
            verdict_reg   <= verdict_next;
            latency_reg   <= (verdict_next == VERDICT_NEW) ? s1_lat_reg : '0;
            reordered_reg <= reordered_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign verdict         = verdict_reg;
    assign latency_ns      = latency_reg;
    assign reordered       = reordered_reg;
    assign delivered_total = deliv_out_reg;
    assign duplicate_total = dup_out_reg;
    assign reorder_total   = reord_out_reg;

endmodule

// ===== rtl/core/pst_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pst_checker
// Port-level checks of the packet sequence tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "packet_sequence_tracker_assert.svh"

module pst_checker
    import pst_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         verdict,
    input logic [STAMP_W-1:0] latency_ns,
    input logic               reordered,
    input logic [DELIV_W-1:0] delivered_total,
    input logic [DUP_W-1:0]   duplicate_total,
    input logic [REORD_W-1:0] reorder_total
);

    // hold a stalled result
    `PST_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(verdict) && $stable(latency_ns))

    // anything but a new delivery reports no latency and no reorder
    `PST_ASSERT_SAME(a_ignored_zero, clk, rst_n, out_valid && verdict != VERDICT_NEW, latency_ns == '0 && !reordered)

    // counts never go down
    `PST_ASSERT_NEXT(a_counts_rise, clk, rst_n, 1'b1, delivered_total >= $past(delivered_total) && duplicate_total >= $past(duplicate_total) && reorder_total >= $past(reorder_total))

    // a reorder needs an earlier delivery and a counted reorder
    `PST_ASSERT_SAME(a_reorder_counted, clk, rst_n, out_valid && reordered, delivered_total > 17'd1 && reorder_total != '0)

endmodule

bind packet_sequence_tracker pst_checker u_pst_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .verdict         (verdict),
    .latency_ns      (latency_ns),
    .reordered       (reordered),
    .delivered_total (delivered_total),
    .duplicate_total (duplicate_total),
    .reorder_total   (reorder_total)
);
